@@ hdl/rtc3w_pkg.sv @@
// ----------------------------------------------------------------------------
// rtc3w_pkg
// Types, codes and conversion helpers for the three-wire RTC access master.
// ----------------------------------------------------------------------------
`default_nettype none

package rtc3w_pkg;

    localparam int CFG_W = 10;
    localparam logic [CFG_W-1:0] CFG_HIGH_TICKS_RESET = 10'd10;

    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    // bits per access: eight command bits then eight data bits
    localparam logic [4:0] CMD_BITS   = 5'd8;
    localparam logic [4:0] TOTAL_BITS = 5'd16;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LOW,
        PH_HIGH
    } t_phase;

    typedef enum logic [2:0] {
        FLD_SECONDS,
        FLD_MINUTES,
        FLD_HOURS,
        FLD_DATE,
        FLD_MONTH,
        FLD_YEAR
    } t_field;

    typedef struct packed {
        logic       func;
        logic       start_req;
        logic [2:0] field;
        logic [7:0] value;
        logic       io_in;
    } t_tick_in;

    typedef struct packed {
        logic       chip_enable;
        logic       serial_clock;
        logic       io_drive;
        logic       io_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_value;
    } t_tick_out;

    function automatic logic field_ok(input logic [2:0] f);
        return f <= 3'(FLD_YEAR);
    endfunction

    function automatic logic [7:0] field_addr(input logic [2:0] f);
        case (t_field'(f))
            FLD_SECONDS: return 8'h80;
            FLD_MINUTES: return 8'h82;
            FLD_HOURS:   return 8'h84;
            FLD_DATE:    return 8'h86;
            FLD_MONTH:   return 8'h88;
            FLD_YEAR:    return 8'h8C;
            default:     return 8'h8C;
        endcase
    endfunction

    function automatic logic [6:0] field_limit(input logic [2:0] f);
        case (t_field'(f))
            FLD_SECONDS: return 7'd60;
            FLD_MINUTES: return 7'd60;
            FLD_HOURS:   return 7'd24;
            FLD_DATE:    return 7'd32;
            FLD_MONTH:   return 7'd13;
            FLD_YEAR:    return 7'd100;
            default:     return 7'd100;
        endcase
    endfunction

    function automatic logic [7:0] field_mask(input logic [2:0] f);
        case (t_field'(f))
            FLD_SECONDS: return 8'h7F;
            FLD_MINUTES: return 8'h7F;
            FLD_HOURS:   return 8'h3F;
            FLD_DATE:    return 8'h3F;
            FLD_MONTH:   return 8'h1F;
            FLD_YEAR:    return 8'hFF;
            default:     return 8'hFF;
        endcase
    endfunction

    // remainder by the field limit: restoring subtraction of limit*16 .. limit*1
    function automatic logic [6:0] mod_limit(input logic [7:0] v, input logic [2:0] f);
        logic [12:0] rem;
        logic [12:0] sub;
        rem = {5'd0, v};
        for (int k = 4; k >= 0; k--) begin
            sub = {6'd0, field_limit(f)} << k;
            if (rem >= sub) begin
                rem = rem - sub;
            end
        end
        return rem[6:0];
    endfunction

    // d below 100: tens digit by restoring subtraction of 80, 40, 20, 10
    function automatic logic [7:0] to_bcd(input logic [6:0] d);
        logic [6:0] rem;
        logic [6:0] sub;
        logic [3:0] tens;
        rem  = d;
        tens = 4'd0;
        for (int k = 3; k >= 0; k--) begin
            sub = 7'd10 << k;
            if (rem >= sub) begin
                rem     = rem - sub;
                tens[k] = 1'b1;
            end
        end
        return {tens, rem[3:0]};
    endfunction

    // high nibble times ten as shift and add
    function automatic logic [7:0] from_bcd(input logic [7:0] b);
        return {1'b0, b[7:4], 3'd0} + {3'd0, b[7:4], 1'b0} + {4'd0, b[3:0]};
    endfunction

endpackage

`default_nettype wire

@@ hdl/rtc3w_in_stage.sv @@
// ----------------------------------------------------------------------------
// rtc3w_in_stage
// Input register for one tick request, released when the sequencer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module rtc3w_in_stage (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_valid,
    output logic                     o_ready,
    input  wire rtc3w_pkg::t_tick_in i_tick,
    input  wire                      i_take,
    output logic                     o_valid,
    output rtc3w_pkg::t_tick_in      o_tick
);

    logic                r_valid;
    rtc3w_pkg::t_tick_in r_tick;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_tick  = r_tick;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_tick <= i_tick;
        end
    end

endmodule

`default_nettype wire

@@ hdl/rtc3w_seq.sv @@
// ----------------------------------------------------------------------------
// rtc3w_seq
// Pin sequencer: advances one tick per request taken and forms the pin levels.
// ----------------------------------------------------------------------------
`default_nettype none

module rtc3w_seq (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_cfg_we,
    input  wire [rtc3w_pkg::CFG_W-1:0] i_cfg_data,
    input  wire                        i_step,
    input  wire rtc3w_pkg::t_tick_in   i_tick,
    output rtc3w_pkg::t_tick_out       o_result
);

    localparam int CW = rtc3w_pkg::CFG_W;

    logic [CW-1:0]     r_high_ticks;
    rtc3w_pkg::t_phase r_phase, n_phase;
    logic [4:0]        r_bit, n_bit;
    logic [CW-1:0]     r_tick_cnt, n_tick_cnt;
    logic [7:0]        r_shift, n_shift;
    logic [7:0]        r_recv, n_recv;
    logic              r_kind, n_kind;
    logic [2:0]        r_field, n_field;
    logic [7:0]        r_last, n_last;
    logic              n_done;
    logic [CW-1:0]     high_len;
    logic [4:0]        bit_inc;

    assign high_len = (r_high_ticks == '0) ? CW'(1) : r_high_ticks;
    assign bit_inc  = r_bit + 5'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_ticks <= rtc3w_pkg::CFG_HIGH_TICKS_RESET;
        end else if (i_cfg_we) begin
            r_high_ticks <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= rtc3w_pkg::PH_IDLE;
            r_bit      <= '0;
            r_tick_cnt <= '0;
            r_shift    <= '0;
            r_recv     <= '0;
            r_kind     <= 1'b0;
            r_field    <= '0;
            r_last     <= '0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_bit      <= n_bit;
            r_tick_cnt <= n_tick_cnt;
            r_shift    <= n_shift;
            r_recv     <= n_recv;
            r_kind     <= n_kind;
            r_field    <= n_field;
            r_last     <= n_last;
        end
    end

    // next state
    always_comb begin
        n_phase    = r_phase;
        n_bit      = r_bit;
        n_tick_cnt = r_tick_cnt;
        n_shift    = r_shift;
        n_recv     = r_recv;
        n_kind     = r_kind;
        n_field    = r_field;
        n_last     = r_last;
        n_done     = 1'b0;
        unique case (r_phase)
            rtc3w_pkg::PH_IDLE: begin
                if (i_tick.start_req && rtc3w_pkg::field_ok(i_tick.field)) begin
                    n_kind     = i_tick.func;
                    n_field    = i_tick.field;
                    n_shift    = rtc3w_pkg::field_addr(i_tick.field)
                                 | {7'd0, i_tick.func == rtc3w_pkg::FUNC_READ};
                    n_recv     = (i_tick.func == rtc3w_pkg::FUNC_WRITE)
                                 ? rtc3w_pkg::to_bcd(
                                       rtc3w_pkg::mod_limit(i_tick.value, i_tick.field))
                                 : 8'd0;
                    n_bit      = '0;
                    n_tick_cnt = '0;
                    n_phase    = rtc3w_pkg::PH_LOW;
                end
            end
            rtc3w_pkg::PH_LOW: begin
                // sample read data before the rising clock edge
                if (r_bit >= rtc3w_pkg::CMD_BITS && r_kind == rtc3w_pkg::FUNC_READ) begin
                    n_recv = r_recv | (8'(i_tick.io_in) << r_bit[2:0]);
                end
                n_tick_cnt = CW'(1);
                n_phase    = rtc3w_pkg::PH_HIGH;
            end
            rtc3w_pkg::PH_HIGH: begin
                if (r_tick_cnt >= high_len) begin
                    n_tick_cnt = '0;
                    if (bit_inc >= rtc3w_pkg::TOTAL_BITS) begin
                        if (r_kind == rtc3w_pkg::FUNC_READ) begin
                            n_last = rtc3w_pkg::from_bcd(
                                         r_recv & rtc3w_pkg::field_mask(r_field));
                        end
                        n_bit   = '0;
                        n_phase = rtc3w_pkg::PH_IDLE;
                        n_done  = 1'b1;
                    end else begin
                        n_bit = bit_inc;
                        // load the data byte after the command, else shift on
                        if (bit_inc == rtc3w_pkg::CMD_BITS) begin
                            n_shift = (r_kind == rtc3w_pkg::FUNC_WRITE) ? r_recv : 8'd0;
                        end else begin
                            n_shift = r_shift >> 1;
                        end
                        n_phase = rtc3w_pkg::PH_LOW;
                    end
                end else begin
                    n_tick_cnt = r_tick_cnt + CW'(1);
                end
            end
            default: begin
                n_phase = rtc3w_pkg::PH_IDLE;
            end
        endcase
    end

    // pin levels follow the state after this tick
    always_comb begin
        o_result.chip_enable  = n_phase != rtc3w_pkg::PH_IDLE;
        o_result.serial_clock = n_phase == rtc3w_pkg::PH_HIGH;
        o_result.io_drive     = o_result.chip_enable
                                && (n_bit < rtc3w_pkg::CMD_BITS
                                    || n_kind == rtc3w_pkg::FUNC_WRITE);
        o_result.io_out       = o_result.io_drive && n_shift[0];
        o_result.busy_res     = o_result.chip_enable;
        o_result.done_res     = n_done;
        o_result.read_value   = n_last;
    end

endmodule

`default_nettype wire

@@ hdl/rtc3w_out_stage.sv @@
// ----------------------------------------------------------------------------
// rtc3w_out_stage
// Result register: holds one tick result until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module rtc3w_out_stage (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_load,
    input  wire rtc3w_pkg::t_tick_out i_result,
    input  wire                       i_ready,
    output logic                      o_can_load,
    output logic                      o_valid,
    output rtc3w_pkg::t_tick_out      o_result
);

    logic                 r_valid;
    rtc3w_pkg::t_tick_out r_result;

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_result   = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

`default_nettype wire

@@ hdl/rtc_three_wire_bcd_access_master.sv @@
// A tick request passes the input register, the sequencer and the result register.
// Throughput: one tick per cycle through both registers while results are taken.
// A stalled consumer holds the result register and the input register fills behind it.
// Reset: synchronous, active low; sequencer idle, clock high ticks 10, read value 0.
// ----------------------------------------------------------------------------
// rtc_three_wire_bcd_access_master
// Tick-driven three-wire master for a real-time clock with BCD time fields.
// ----------------------------------------------------------------------------
`default_nettype none

module rtc_three_wire_bcd_access_master (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire [rtc3w_pkg::CFG_W-1:0] i_cfg_data,
    input  wire                        i_in_valid,
    output logic                       o_in_ready,
    input  wire                        i_func,
    input  wire                        i_start_req,
    input  wire [2:0]                  i_field,
    input  wire [7:0]                  i_value,
    input  wire                        i_io_in,
    output logic                       o_out_valid,
    input  wire                        i_out_ready,
    output logic                       o_chip_enable,
    output logic                       o_serial_clock,
    output logic                       o_io_drive,
    output logic                       o_io_out,
    output logic                       o_busy_res,
    output logic                       o_done_res,
    output logic [7:0]                 o_read_value
);

    rtc3w_pkg::t_tick_in  in_tick;
    rtc3w_pkg::t_tick_in  reg_tick;
    rtc3w_pkg::t_tick_out seq_result;
    rtc3w_pkg::t_tick_out out_result;
    logic                 reg_valid;
    logic                 out_can_load;
    logic                 step;

    assign o_cfg_ready = 1'b1;

    assign in_tick.func      = i_func;
    assign in_tick.start_req = i_start_req;
    assign in_tick.field     = i_field;
    assign in_tick.value     = i_value;
    assign in_tick.io_in     = i_io_in;

    assign step = reg_valid && out_can_load;

    rtc3w_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_tick  (in_tick),
        .i_take  (step),
        .o_valid (reg_valid),
        .o_tick  (reg_tick)
    );

    rtc3w_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_step     (step),
        .i_tick     (reg_tick),
        .o_result   (seq_result)
    );

    rtc3w_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (step),
        .i_result   (seq_result),
        .i_ready    (i_out_ready),
        .o_can_load (out_can_load),
        .o_valid    (o_out_valid),
        .o_result   (out_result)
    );

    assign o_chip_enable  = out_result.chip_enable;
    assign o_serial_clock = out_result.serial_clock;
    assign o_io_drive     = out_result.io_drive;
    assign o_io_out       = out_result.io_out;
    assign o_busy_res     = out_result.busy_res;
    assign o_done_res     = out_result.done_res;
    assign o_read_value   = out_result.read_value;

    a_done_drops_ce: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_done_res |-> !o_chip_enable)
        else $error("done reported with chip enable high");

    a_clk_within_ce: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_serial_clock |-> o_chip_enable)
        else $error("serial clock high outside an access");

    a_out_needs_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_io_out |-> o_io_drive)
        else $error("data level driven while pin released");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

endmodule

`default_nettype wire
